@@ rtl/ipub_pkg.sv @@
// ----------------------------------------------------------------------------
// ipub_pkg
// shared types, constants and header helpers for the ipv4/udp packet builder
// ----------------------------------------------------------------------------
package ipub_pkg;

  localparam logic [15:0] MAX_PAYLOAD   = 16'd65507;
  localparam logic [15:0] IP_HDR_BYTES  = 16'd28;
  localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
  localparam logic [4:0]  LAST_HDR_IDX  = 5'd27;
  localparam int          QUEUE_DEPTH   = 4;
  localparam int          QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int          QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  VER_IHL       = 8'h45;
  localparam logic [7:0]  TTL_MAX       = 8'hFF;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_PAYLOAD = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    REG_SRC_ADDR  = 2'd0,
    REG_DST_ADDR  = 2'd1,
    REG_SRC_PORT  = 2'd2,
    REG_DST_PORT  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    JOB_HEADER  = 2'd0,
    JOB_PAYLOAD = 2'd1,
    JOB_ERROR   = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic        command;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       framing_error;
  } out_item_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } cfg_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [15:0] len;
    logic [15:0] csum;
    logic [7:0]  data;
    logic        last;
  } job_t;

  function automatic logic [15:0] hdr_checksum(logic [15:0] total_len, cfg_t cfg);
    logic [18:0] sum;
    logic [16:0] fold1;
    logic [16:0] fold2;
    sum = 19'h04500 + 19'(total_len) + 19'({TTL_MAX, PROTO_UDP})
        + 19'(cfg.src_addr[31:16]) + 19'(cfg.src_addr[15:0])
        + 19'(cfg.dst_addr[31:16]) + 19'(cfg.dst_addr[15:0]);
    fold1 = 17'(sum[18:16]) + 17'(sum[15:0]);
    fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
    return ~fold2[15:0];
  endfunction

  function automatic logic [7:0] hdr_byte(logic [4:0] idx, logic [15:0] len,
                                          logic [15:0] csum, cfg_t cfg);
    logic [15:0] total_len;
    logic [15:0] udp_len;
    logic [7:0]  b;
    total_len = IP_HDR_BYTES + len;
    udp_len   = UDP_HDR_BYTES + len;
    case (idx)
      5'd0:    b = VER_IHL;
      5'd2:    b = total_len[15:8];
      5'd3:    b = total_len[7:0];
      5'd8:    b = TTL_MAX;
      5'd9:    b = PROTO_UDP;
      5'd10:   b = csum[15:8];
      5'd11:   b = csum[7:0];
      5'd12:   b = cfg.src_addr[31:24];
      5'd13:   b = cfg.src_addr[23:16];
      5'd14:   b = cfg.src_addr[15:8];
      5'd15:   b = cfg.src_addr[7:0];
      5'd16:   b = cfg.dst_addr[31:24];
      5'd17:   b = cfg.dst_addr[23:16];
      5'd18:   b = cfg.dst_addr[15:8];
      5'd19:   b = cfg.dst_addr[7:0];
      5'd20:   b = cfg.src_port[15:8];
      5'd21:   b = cfg.src_port[7:0];
      5'd22:   b = cfg.dst_port[15:8];
      5'd23:   b = cfg.dst_port[7:0];
      5'd24:   b = udp_len[15:8];
      5'd25:   b = udp_len[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/ipub_queue.sv @@
// ----------------------------------------------------------------------------
// ipub_queue
// short job queue between the command front end and the byte back end
// ----------------------------------------------------------------------------
module ipub_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  ipub_pkg::job_t wr_job,
  input  logic          rd,
  output logic          full,
  output logic          valid,
  output ipub_pkg::job_t rd_job
);
  import ipub_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_wr;
  logic do_rd;

  assign full   = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid  = (count != '0);
  assign rd_job = slots[rd_ptr];
  assign do_wr  = wr && !full;
  assign do_rd  = rd && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/ipub_front.sv @@
// ----------------------------------------------------------------------------
// ipub_front
// accepts commands, tracks the open packet and turns each command into a job
// ----------------------------------------------------------------------------
module ipub_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ipub_pkg::in_item_t item,
  input  ipub_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              q_wr,
  output ipub_pkg::job_t    q_job
);
  import ipub_pkg::*;

  logic [15:0] bytes_remaining;
  logic        packet_open;

  logic [15:0] len_sat;
  logic        accept;
  logic        stray;

  assign accept  = push && !q_full;
  assign q_wr    = accept;
  assign len_sat = (item.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : item.payload_length;
  assign stray   = !packet_open || (bytes_remaining == 16'd0);

  always_comb begin
    q_job      = '0;
    q_job.data = item.payload_byte;
    if (item.command == CMD_START) begin
      q_job.kind = JOB_HEADER;
      q_job.len  = len_sat;
      q_job.csum = hdr_checksum(IP_HDR_BYTES + len_sat, cfg);
      q_job.last = (len_sat == 16'd0);
    end else if (stray) begin
      q_job.kind = JOB_ERROR;
    end else begin
      q_job.kind = JOB_PAYLOAD;
      q_job.last = (bytes_remaining == 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= '0;
      packet_open     <= 1'b0;
    end else if (accept) begin
      if (item.command == CMD_START) begin
        bytes_remaining <= len_sat;
        packet_open     <= (len_sat != 16'd0);
      end else if (!stray) begin
        bytes_remaining <= bytes_remaining - 16'd1;
        if (bytes_remaining == 16'd1) begin
          packet_open <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/ipub_back.sv @@
// ----------------------------------------------------------------------------
// ipub_back
// expands jobs into packet bytes and holds the output register
// ----------------------------------------------------------------------------
module ipub_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ipub_pkg::job_t     q_job,
  input  ipub_pkg::cfg_t     cfg,
  input  logic               pop,
  output logic               q_rd,
  output logic               empty,
  output ipub_pkg::out_item_t result
);
  import ipub_pkg::*;

  logic [4:0] idx;
  logic       out_valid;

  logic       advance;
  logic       produce;
  logic       hdr_done;
  out_item_t  next_beat;

  assign advance  = !out_valid || pop;
  assign produce  = advance && q_valid;
  assign hdr_done = (idx == LAST_HDR_IDX);
  assign empty    = !out_valid;

  always_comb begin
    next_beat = '0;
    q_rd      = 1'b0;
    case (q_job.kind)
      JOB_HEADER: begin
        next_beat.packet_byte = hdr_byte(idx, q_job.len, q_job.csum, cfg);
        next_beat.last_byte   = q_job.last && hdr_done;
        q_rd                  = produce && hdr_done;
      end
      JOB_PAYLOAD: begin
        next_beat.packet_byte = q_job.data;
        next_beat.last_byte   = q_job.last;
        q_rd                  = produce;
      end
      JOB_ERROR: begin
        next_beat.framing_error = 1'b1;
        q_rd                    = produce;
      end
      default: begin
        q_rd = produce;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      result <= next_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= q_valid;
      end
      if (produce && q_job.kind == JOB_HEADER) begin
        idx <= hdr_done ? 5'd0 : idx + 5'd1;
      end
    end
  end

endmodule

@@ rtl/ipv4_udp_packet_builder.sv @@
// ----------------------------------------------------------------------------
// ipv4_udp_packet_builder
// frames a udp payload into an ipv4 packet byte stream
// ----------------------------------------------------------------------------
// input side is a queue write port: a beat is taken when push is high and
// full is low. a start command (command 0) carries the payload length and
// yields the 28 header bytes; a payload command (command 1) yields one byte,
// with last_byte set on the final payload byte. a payload byte with no packet
// open yields one beat with framing_error set and the byte dropped.
// result side is a queue read port: the oldest beat sits on result while
// empty is low and leaves when pop is high.
// a taken command is written to the job queue. the byte engine emits one beat
// per cycle while the output register is empty or popped: payload commands
// flow at one per cycle, a start command holds the engine for its 28 header
// bytes while a four-entry job queue keeps taking commands until it fills.
// when pop stays low the output register holds, the engine stops, and full
// rises once the job queue is full. reset clears the addresses and ports to
// zero, closes any packet and empties the queue and the output register.
// wr_en, wr_index and wr_data write the address and port registers; the user
// must use them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module ipv4_udp_packet_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  ipub_pkg::in_item_t  item,
  output logic                empty,
  input  logic                pop,
  output ipub_pkg::out_item_t result,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [31:0]         wr_data
);
  import ipub_pkg::*;

  cfg_t cfg;

  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_valid;
  job_t q_wr_job;
  job_t q_rd_job;

  assign full = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_SRC_ADDR: cfg.src_addr <= wr_data;
        REG_DST_ADDR: cfg.dst_addr <= wr_data;
        REG_SRC_PORT: cfg.src_port <= wr_data[15:0];
        REG_DST_PORT: cfg.dst_port <= wr_data[15:0];
        default: cfg <= cfg;
      endcase
    end
  end

  ipub_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .cfg    (cfg),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_job  (q_wr_job)
  );

  ipub_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_job (q_wr_job),
    .rd     (q_rd),
    .full   (q_full),
    .valid  (q_valid),
    .rd_job (q_rd_job)
  );

  ipub_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (q_rd_job),
    .cfg     (cfg),
    .pop     (pop),
    .q_rd    (q_rd),
    .empty   (empty),
    .result  (result)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ipv4/udp packet builder
// ----------------------------------------------------------------------------
// commands are pushed through the queue-style input with random gaps, and the
// result queue is drained with random stalls. a predictor in the bench keeps
// its own copy of the address and port registers and of the open-packet
// count, expands each accepted command into the beats it should cause, and a
// checker compares every popped beat with the oldest expected one. directed
// tests cover register extremes, empty and oversized packets, abandoned
// packets and stray payload bytes; random traffic then runs mostly complete
// packets with random content, mixed with abandoned packets and stray bytes,
// across several register settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipub_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  in_item_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  out_item_t   result;
  logic        wr_en = 1'b0;
  logic [1:0]  wr_index = '0;
  logic [31:0] wr_data = '0;

  logic [31:0] src_ip = '0;
  logic [31:0] dst_ip = '0;
  logic [15:0] src_udp_port = '0;
  logic [15:0] dst_udp_port = '0;
  logic [15:0] payload_left = '0;

  out_item_t   expected_beats[$];
  int unsigned mismatches = 0;
  bit          steady = 1'b0;
  int unsigned pop_hold = 0;

  ipv4_udp_packet_builder u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] ip_header_sum(logic [15:0] total_len);
    logic [31:0] acc;
    acc = 32'h4500 + 32'(total_len) + 32'({TTL_MAX, PROTO_UDP})
        + 32'(src_ip[31:16]) + 32'(src_ip[15:0])
        + 32'(dst_ip[31:16]) + 32'(dst_ip[15:0]);
    acc = 32'(acc[31:16]) + 32'(acc[15:0]);
    acc = 32'(acc[31:16]) + 32'(acc[15:0]);
    return ~acc[15:0];
  endfunction

  function automatic void predict_beats(in_item_t it);
    logic [15:0]  len;
    logic [15:0]  total_len;
    logic [15:0]  udp_len;
    logic [223:0] hdr;
    out_item_t    beat;
    if (it.command == CMD_START) begin
      len = (it.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD : it.payload_length;
      total_len = len + 16'd28;
      udp_len = len + 16'd8;
      hdr = {VER_IHL, 8'h00, total_len, 32'h0, TTL_MAX, PROTO_UDP,
             ip_header_sum(total_len), src_ip, dst_ip, src_udp_port, dst_udp_port,
             udp_len, 16'h0};
      for (int i = 0; i < 28; i++) begin
        beat.packet_byte = hdr[223 - 8 * i -: 8];
        beat.last_byte = (i == 27) && (len == 16'd0);
        beat.framing_error = 1'b0;
        expected_beats.push_back(beat);
      end
      payload_left = len;
    end else if (payload_left == 16'd0) begin
      beat = '{packet_byte: 8'h00, last_byte: 1'b0, framing_error: 1'b1};
      expected_beats.push_back(beat);
    end else begin
      payload_left = payload_left - 16'd1;
      beat.packet_byte = it.payload_byte;
      beat.last_byte = (payload_left == 16'd0);
      beat.framing_error = 1'b0;
      expected_beats.push_back(beat);
    end
  endfunction

  task automatic report_mismatch(string what, out_item_t e, out_item_t a);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected byte %02h last %0b err %0b, %s %02h last %0b err %0b",
               what, e.packet_byte, e.last_byte, e.framing_error, "got byte",
               a.packet_byte, a.last_byte, a.framing_error);
  endtask

  // result side: random stalls on pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold != 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop <= 1'b1;
      pop_hold <= pick_gap();
    end
  end

  // a beat leaves at the next edge when pop is high and empty is low
  always @(negedge clk) begin
    out_item_t e;
    if (!rst && pop && !empty) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", '0, result);
      end else begin
        e = expected_beats.pop_front();
        if (result.packet_byte !== e.packet_byte || result.last_byte !== e.last_byte ||
            result.framing_error !== e.framing_error)
          report_mismatch("wrong field", e, result);
      end
    end
  end

  task automatic send_item(cmd_t c, logic [15:0] len, logic [7:0] data);
    in_item_t    it;
    bit          taken;
    int unsigned gap;
    it.command = c;
    it.payload_length = len;
    it.payload_byte = data;
    push <= 1'b1;
    item <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      if (taken) predict_beats(it);
      @(posedge clk);
    end
    gap = pick_gap();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(logic [15:0] len, int unsigned n_bytes);
    send_item(CMD_START, len, 8'($urandom));
    repeat (n_bytes) send_item(CMD_PAYLOAD, 16'($urandom), 8'($urandom));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] data);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_SRC_ADDR: src_ip = data;
      REG_DST_ADDR: dst_ip = data;
      REG_SRC_PORT: src_udp_port = data[15:0];
      REG_DST_PORT: dst_udp_port = data[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic load_config(logic [31:0] sa, logic [31:0] da, logic [15:0] sp,
                             logic [15:0] dp);
    wait_idle();
    write_reg(REG_SRC_ADDR, sa);
    write_reg(REG_DST_ADDR, da);
    write_reg(REG_SRC_PORT, {16'h0, sp});
    write_reg(REG_DST_PORT, {16'h0, dp});
  endtask

  task automatic test_reset_config();
    send_frame(16'd0, 0);
    send_item(CMD_PAYLOAD, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_length_limits();
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_frame(16'hFFFF, 1);
    send_frame(16'd65508, 0);
    send_frame(MAX_PAYLOAD, 0);
    send_frame(16'd1, 0);
    send_item(CMD_PAYLOAD, 16'h0000, 8'h00);
    send_item(CMD_PAYLOAD, 16'h1234, 8'h5A);
  endtask

  task automatic test_short_packets();
    load_config(32'h8000_0001, 32'h7FFF_FFFE, 16'h8000, 16'h00FF);
    send_frame(16'd0, 0);
    send_frame(16'd2, 2);
    send_frame(16'd3, 1);
    send_frame(16'd1, 1);
    send_item(CMD_PAYLOAD, 16'd7, 8'hC3);
    send_frame(16'd5, 1);
    send_frame(16'd0, 0);
    send_item(CMD_PAYLOAD, 16'd0, 8'h3C);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int phase_left;
    int unsigned kind;
    int unsigned len;
    int unsigned nb;
    sent = 0;
    phase_left = 0;
    while (sent < n_items) begin
      if (phase_left <= 0) begin
        load_config(pick_word(), pick_word(), 16'(pick_word()), 16'(pick_word()));
        steady = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(60, 140);
      end
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
        send_frame(16'(len), len);
        nb = len + 1;
      end else if (kind < 88) begin
        len = $urandom_range(0, 65535);
        nb = $urandom_range(0, 4);
        send_frame(16'(len), nb);
        nb = nb + 1;
      end else begin
        send_item(CMD_PAYLOAD, 16'($urandom), 8'($urandom));
        nb = 1;
      end
      sent += nb;
      phase_left -= nb;
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_length_limits();
    test_short_packets();
    test_random_traffic(500);
    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ipub_pkg.sv
rtl/ipub_queue.sv
rtl/ipub_front.sv
rtl/ipub_back.sv
rtl/ipv4_udp_packet_builder.sv
sim/tb_top.sv
